/* src/mvp_pkg.sv */
package mvp_pkg;

    // Input operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // Configuration register indexes.
    localparam int   REG_IDX_W    = 1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

    // Field widths fixed by the interface.
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int ROW_W      = 16;
    localparam int COLS_REG_W = 9;
    localparam int CFG_DATA_W = 16;

    // Store address as carried in the queue, wide enough for the largest store.
    localparam int ADDR_MAX_W = 12;

    // One queue entry: a classified word on its way to the back end.
    typedef struct packed {
        logic                         is_load;
        logic [ADDR_MAX_W-1:0]        addr;
        logic signed [VALUE_W-1:0]    value;
        logic                         row_end;
        logic [ROW_W-1:0]             row_index;
        logic                         last_row;
    } t_mvp_entry;

endpackage

/* src/mvp_if.sv */
interface mvp_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         index;
    logic signed [31:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface mvp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] row_sum;
    logic [15:0]        row_index;
    logic               last_row;

    modport source (output valid, output row_sum, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_sum, input row_index, input last_row,
                    output ready);
endinterface

/* src/mvp_ram.sv */
module mvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mvp_fifo.sv */
module mvp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mvp_pkg::t_mvp_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output mvp_pkg::t_mvp_entry o_entry
);
    import mvp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_mvp_entry     r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [PW:0]    r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

/* src/mvp_front.sv */
module mvp_front #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 65535
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mvp_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [mvp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mvp_in_if.sink                             i_mat,
    input  logic                               i_full,
    output logic                               o_push,
    output mvp_pkg::t_mvp_entry                o_entry
);
    import mvp_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);

    logic [COLS_REG_W-1:0] r_num_cols;
    logic [ROW_W-1:0]      r_num_rows;
    logic [CW-1:0]         r_col;
    logic [ROW_W-1:0]      r_row;

    logic [NW-1:0]         cols_eff;
    logic [ROW_W-1:0]      rows_eff;
    logic [NW:0]           col_next;
    logic [ROW_W:0]        row_next;
    logic                  row_end, last, in_range, is_matrix, accept;

    // Clamp the column and row counts to the legal range.
    always_comb begin
        if (r_num_cols == '0) begin
            cols_eff = NW'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = NW'(MAX_COLS);
        end else begin
            cols_eff = NW'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            rows_eff = ROW_W'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = r_num_rows;
        end
    end

    assign col_next  = (NW+1)'(r_col) + 1'b1;
    assign row_end   = (col_next >= {1'b0, cols_eff});
    assign row_next  = {1'b0, r_row} + 1'b1;
    assign last      = (row_next >= {1'b0, rows_eff});
    assign in_range  = (32'(i_mat.index) < MAX_COLS);
    assign is_matrix = (i_mat.op == OP_MATRIX);

    assign i_mat.ready = !i_full;
    assign accept      = i_mat.valid && !i_full;
    // Loads beyond the store are dropped here and never reach the queue.
    assign o_push      = accept && (is_matrix || in_range);

    always_comb begin
        o_entry.is_load   = !is_matrix;
        o_entry.addr      = is_matrix ? ADDR_MAX_W'(r_col) : ADDR_MAX_W'(i_mat.index);
        o_entry.value     = i_mat.value;
        o_entry.row_end   = is_matrix && row_end;
        o_entry.row_index = r_row;
        o_entry.last_row  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= COLS_REG_W'(1);
            r_num_rows <= ROW_W'(1);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NUM_COLS: begin
                        r_num_cols <= i_cfg_data[COLS_REG_W-1:0];
                    end
                    REG_NUM_ROWS: begin
                        r_num_rows <= i_cfg_data[ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept && is_matrix) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= last ? '0 : row_next[ROW_W-1:0];
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

/* src/mvp_back.sv */
module mvp_back #(
    parameter int MAX_COLS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  mvp_pkg::t_mvp_entry i_entry,
    output logic                o_pop,
    mvp_out_if.source           o_res
);
    import mvp_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                      advance;
    logic [VALUE_W-1:0]        ram_rdata;
    logic                      ram_re;

    // Issue stage: store read in flight.
    logic                      r_a_valid;
    logic signed [VALUE_W-1:0] r_a_value;
    logic                      r_a_end;
    logic [ROW_W-1:0]          r_a_row;
    logic                      r_a_last;

    // Product stage.
    logic                      r_b_valid;
    logic [VALUE_W-1:0]        r_b_prod;
    logic                      r_b_end;
    logic [ROW_W-1:0]          r_b_row;
    logic                      r_b_last;
    logic [2*VALUE_W-1:0]      prod_full;

    // Accumulate and result register.
    logic [VALUE_W-1:0]        r_acc;
    logic [VALUE_W-1:0]        sum;
    logic                      r_o_valid;
    logic [VALUE_W-1:0]        r_o_sum;
    logic [ROW_W-1:0]          r_o_row;
    logic                      r_o_last;

    // A waiting result freezes the whole back end.
    assign advance = !r_o_valid || o_res.ready;
    assign o_pop   = advance && !i_empty;
    assign ram_re  = o_pop && !i_entry.is_load;

    mvp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_entry.is_load),
        .i_waddr (i_entry.addr[CW-1:0]),
        .i_wdata (i_entry.value),
        .i_re    (ram_re),
        .i_raddr (i_entry.addr[CW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign prod_full = r_a_value * ram_rdata;
    assign sum       = r_acc + r_b_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else if (advance) begin
            r_a_valid <= ram_re;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid && r_b_end;
            if (r_b_valid) begin
                r_acc <= r_b_end ? '0 : sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_value <= i_entry.value;
            r_a_end   <= i_entry.row_end;
            r_a_row   <= i_entry.row_index;
            r_a_last  <= i_entry.last_row;
            r_b_prod  <= prod_full[VALUE_W-1:0];
            r_b_end   <= r_a_end;
            r_b_row   <= r_a_row;
            r_b_last  <= r_a_last;
            if (r_b_valid && r_b_end) begin
                r_o_sum  <= sum;
                r_o_row  <= r_b_row;
                r_o_last <= r_b_last;
            end
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.row_sum   = r_o_sum;
    assign o_res.row_index = r_o_row;
    assign o_res.last_row  = r_o_last;

endmodule

/* src/matrix_vector_product.sv */
// Channel   Role    Words carried
// i_mat     sink    op, index, value: vector loads and row-major matrix elements
// o_res     source  row_sum, row_index, last_row: one word per completed row
// i_cfg_*   write   register 0 num_cols, register 1 num_rows
//
// One word is taken per cycle while the queue has room; a row result, once its last
// element is accepted, passes through the queue, the registered store read and the
// product register, after which the sum lands in the result register.
// Reset is synchronous and active low; it clears the counters, the queue, the
// pipeline and the accumulator. The vector store is not cleared.
// A result held at the output freezes the back end; the four-entry queue keeps
// input ready high until it fills.

module matrix_vector_product #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 65535
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mvp_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [mvp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mvp_in_if.sink                          i_mat,
    mvp_out_if.source                       o_res
);
    import mvp_pkg::*;

    // Classified words travel from the front end to the back end via the queue.
    t_mvp_entry push_entry, pop_entry;
    logic       push, full, pop, empty;

    // The front end owns the registers and the column and row counters, so
    // every word leaves it already tagged with its store address and row flags.
    mvp_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mat       (i_mat),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    mvp_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (pop_entry)
    );

    // The back end handles words strictly in order, so a load always lands in
    // the store before any later matrix element reads it.
    mvp_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

/* src/mvp_checker.sv */
module mvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_sum,
    input logic [15:0] i_out_row,
    input logic        i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_sum) && $stable(i_out_row) && $stable(i_out_last))
        else $error("result word changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind matrix_vector_product mvp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_mat.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_sum   (o_res.row_sum),
    .i_out_row   (o_res.row_index),
    .i_out_last  (o_res.last_row)
);
